>>> hw/rtl/mpsq_pkg.sv
package mpsq_pkg;

   localparam int ADDR_W = 6;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 32;
   localparam int WORDS  = 64;

   localparam logic signed [63:0] MAX64 = 64'sd2147483647;
   localparam logic signed [63:0] MIN64 = -64'sd2147483648;

   typedef struct packed {
      logic             load_en;
      logic             clear_flag;
      logic             mac_valid;
      logic             mac_first;
      logic             mac_last;
      logic [IDX_W-1:0] mac_i;
      logic [IDX_W-1:0] mac_j;
      logic [IDX_W-1:0] mac_k;
      logic             x_base;
      logic             y_base;
      logic             cur_bank;
      logic             emit_valid;
      logic             emit_ident;
      logic             emit_last;
      logic [IDX_W-1:0] emit_row;
      logic [IDX_W-1:0] emit_col;
   } ctl_cmd_type;

   typedef struct packed {
      logic emit_ready;
   } dp_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > MAX64) begin
         return 32'sh7fffffff;
      end else if (v < MIN64) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic ovf32(input logic signed [63:0] v);
      return (v > MAX64) || (v < MIN64);
   endfunction

endpackage

>>> hw/rtl/mpsq_ctrl.sv
module mpsq_ctrl #(
   parameter int DIM_MAX = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [2:0]                req_row,
   input  logic [2:0]                req_col,
   input  logic [31:0]               req_exponent,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [3:0]                csr_data,
   input  mpsq_pkg::dp_stat_type     stat,
   output mpsq_pkg::ctl_cmd_type     cmd
);
   import mpsq_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_NEXT  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [3:0]       size_ff, size_in;
   logic [31:0]      exp_ff, exp_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             sqr_ff, sqr_in;
   logic             bank_ff, bank_in;
   logic             src_base_ff, src_base_in;
   logic             ident_ff, ident_in;
   logic [1:0]       drain_ff, drain_in;
   logic [3:0]       n_eff;
   logic [IDX_W-1:0] nm1;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      if (size_ff == 4'd0) begin
         n_eff = 4'd1;
      end else if (size_ff > 4'(DIM_MAX)) begin
         n_eff = 4'(DIM_MAX);
      end else begin
         n_eff = size_ff;
      end
      nm1 = IDX_W'(n_eff - 4'd1);
   end

   always_comb begin
      state_in    = state_ff;
      size_in     = size_ff;
      exp_in      = exp_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      sqr_in      = sqr_ff;
      bank_in     = bank_ff;
      src_base_in = src_base_ff;
      ident_in    = ident_ff;
      drain_in    = drain_ff;
      cmd         = '0;
      cmd.mac_i   = i_ff;
      cmd.mac_j   = j_ff;
      cmd.mac_k   = k_ff;
      cmd.x_base  = src_base_ff;
      cmd.y_base  = src_base_ff | ~sqr_ff;
      cmd.cur_bank   = bank_ff;
      cmd.emit_ident = ident_ff;
      cmd.emit_row   = i_ff;
      cmd.emit_col   = j_ff;
      cmd.emit_last  = (i_ff == nm1) && (j_ff == nm1);

      if (csr_valid) begin
         size_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_cmd) begin
                  cmd.load_en = (int'(req_row) < DIM_MAX) && (int'(req_col) < DIM_MAX);
               end else begin
                  cmd.clear_flag = 1'b1;
                  exp_in = req_exponent;
                  cnt_in = 5'd31;
                  i_in   = '0;
                  j_in   = '0;
                  k_in   = '0;
                  src_base_in = 1'b1;
                  if (req_exponent == 32'd0) begin
                     ident_in = 1'b1;
                     state_in = ST_EMIT;
                  end else begin
                     ident_in = 1'b0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // Shift out leading zeros; the top set bit itself is consumed too.
            exp_in = {exp_ff[30:0], 1'b0};
            if (exp_ff[31]) begin
               state_in = ST_NEXT;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_NEXT: begin
            if (cnt_ff == 5'd0) begin
               state_in = ST_EMIT;
            end else begin
               sqr_in   = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mac_valid = 1'b1;
            cmd.mac_first = (k_ff == '0);
            cmd.mac_last  = (k_ff == nm1);
            if (k_ff == nm1) begin
               k_in = '0;
               if (j_ff == nm1) begin
                  j_in = '0;
                  if (i_ff == nm1) begin
                     i_in     = '0;
                     drain_in = 2'd0;
                     state_in = ST_DRAIN;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // The drain lets the last write land before the next read.
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2) begin
               bank_in     = ~bank_ff;
               src_base_in = 1'b0;
               if (sqr_ff && exp_ff[31]) begin
                  sqr_in   = 1'b0;
                  state_in = ST_MUL;
               end else begin
                  exp_in   = {exp_ff[30:0], 1'b0};
                  cnt_in   = cnt_ff - 5'd1;
                  state_in = ST_NEXT;
               end
            end
         end
         ST_EMIT: begin
            if (stat.emit_ready) begin
               cmd.emit_valid = 1'b1;
               if (j_ff == nm1) begin
                  j_in = '0;
                  if (i_ff == nm1) begin
                     i_in     = '0;
                     state_in = ST_IDLE;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         size_ff     <= 4'd8;
         exp_ff      <= '0;
         cnt_ff      <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
         sqr_ff      <= 1'b0;
         bank_ff     <= 1'b0;
         src_base_ff <= 1'b0;
         ident_ff    <= 1'b0;
         drain_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         size_ff     <= size_in;
         exp_ff      <= exp_in;
         cnt_ff      <= cnt_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         k_ff        <= k_in;
         sqr_ff      <= sqr_in;
         bank_ff     <= bank_in;
         src_base_ff <= src_base_in;
         ident_ff    <= ident_in;
         drain_ff    <= drain_in;
      end
   end

endmodule

>>> hw/rtl/mpsq_datapath.sv
module mpsq_datapath #(
   parameter int FRAC_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mpsq_pkg::ctl_cmd_type cmd,
   output mpsq_pkg::dp_stat_type stat,
   input  logic [2:0]            req_row,
   input  logic [2:0]            req_col,
   input  logic signed [31:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_out_row,
   output logic [2:0]            rsp_out_col,
   output logic signed [31:0]    rsp_out_value,
   output logic                  rsp_last,
   output logic                  rsp_saturated
);
   import mpsq_pkg::*;

   localparam logic signed [DATA_W-1:0] ONE = DATA_W'(32'd1 << FRAC_BITS);

   logic signed [DATA_W-1:0] base_mem [WORDS];
   logic signed [DATA_W-1:0] bank0_mem [WORDS];
   logic signed [DATA_W-1:0] bank1_mem [WORDS];

   logic [ADDR_W-1:0] addr_a, addr_b;
   logic signed [DATA_W-1:0] ba_ff, bb_ff, b0a_ff, b0b_ff, b1a_ff, b1b_ff;

   logic             s1_valid_ff, s1_first_ff, s1_last_ff, s1_dest_ff, s1_xb_ff, s1_yb_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic             s2_valid_ff, s2_first_ff, s2_last_ff, s2_dest_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic signed [DATA_W-1:0] x_val, y_val;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] shifted, sum_wide;
   logic signed [DATA_W-1:0] prod_c, acc_base, acc_ff, acc_in;
   logic             flag_ff, flag_in;

   logic             e1_valid_ff, e1_ident_ff, e1_base_ff, e1_bank_ff, e1_last_ff;
   logic [IDX_W-1:0] e1_row_ff, e1_col_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] emit_val;

   assign addr_a = cmd.emit_valid ? {cmd.emit_row, cmd.emit_col} : {cmd.mac_i, cmd.mac_k};
   assign addr_b = {cmd.mac_k, cmd.mac_j};

   // A new element is read only when the output register is sure to be free.
   assign stat.emit_ready = !e1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         base_mem[{req_row, req_col}] <= req_value;
      end
      ba_ff <= base_mem[addr_a];
      bb_ff <= base_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_last_ff && !s2_dest_ff) begin
         bank0_mem[s2_addr_ff] <= acc_in;
      end
      b0a_ff <= bank0_mem[addr_a];
      b0b_ff <= bank0_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_last_ff && s2_dest_ff) begin
         bank1_mem[s2_addr_ff] <= acc_in;
      end
      b1a_ff <= bank1_mem[addr_a];
      b1b_ff <= bank1_mem[addr_b];
   end

   // The source bank is the one opposite the write destination.
   always_comb begin
      if (s1_xb_ff) begin
         x_val = ba_ff;
      end else begin
         x_val = s1_dest_ff ? b0a_ff : b1a_ff;
      end
      if (s1_yb_ff) begin
         y_val = bb_ff;
      end else begin
         y_val = s1_dest_ff ? b0b_ff : b1b_ff;
      end
      prod_in = x_val * y_val;
   end

   always_comb begin
      shifted  = prod_ff >>> FRAC_BITS;
      prod_c   = sat32(shifted);
      acc_base = s2_first_ff ? '0 : acc_ff;
      sum_wide = 64'(acc_base) + 64'(prod_c);
      acc_in   = sat32(sum_wide);
      flag_in  = flag_ff;
      if (cmd.clear_flag) begin
         flag_in = 1'b0;
      end else if (s2_valid_ff && (ovf32(shifted) || ovf32(sum_wide))) begin
         flag_in = 1'b1;
      end
   end

   always_comb begin
      if (e1_ident_ff) begin
         emit_val = (e1_row_ff == e1_col_ff) ? ONE : '0;
      end else if (e1_base_ff) begin
         emit_val = ba_ff;
      end else begin
         emit_val = e1_bank_ff ? b1a_ff : b0a_ff;
      end
      rsp_valid_in = rsp_valid_ff;
      if (e1_valid_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.mac_first;
      s1_last_ff  <= cmd.mac_last;
      s1_dest_ff  <= ~cmd.cur_bank;
      s1_xb_ff    <= cmd.x_base;
      s1_yb_ff    <= cmd.y_base;
      s1_addr_ff  <= {cmd.mac_i, cmd.mac_j};
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_dest_ff  <= s1_dest_ff;
      s2_addr_ff  <= s1_addr_ff;
      prod_ff     <= prod_in;
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      e1_ident_ff <= cmd.emit_ident;
      e1_base_ff  <= cmd.x_base;
      e1_bank_ff  <= cmd.cur_bank;
      e1_last_ff  <= cmd.emit_last;
      e1_row_ff   <= cmd.emit_row;
      e1_col_ff   <= cmd.emit_col;
      if (e1_valid_ff) begin
         rsp_out_row   <= e1_row_ff;
         rsp_out_col   <= e1_col_ff;
         rsp_out_value <= emit_val;
         rsp_last      <= e1_last_ff;
         rsp_saturated <= flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         e1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flag_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.mac_valid;
         s2_valid_ff  <= s1_valid_ff;
         e1_valid_ff  <= cmd.emit_valid;
         rsp_valid_ff <= rsp_valid_in;
         flag_ff      <= flag_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/matrix_power_by_squaring_core.sv
// Channel   Direction  Handshake         Word
// req_      in         valid / stall     cmd, row, col, value, exponent
// rsp_      out        valid / stall     out_row, out_col, out_value, last, saturated
// csr_      in         valid / ready     data = matrix_size
//
// A load word is written straight into the base store. A run scans for the top exponent
// bit, then computes each matrix product as n*n*n multiply-accumulates (one per cycle on
// a single MAC unit) and a drain, with one step per remaining exponent bit; result words
// then go out one at a time while the output is not stalled.
// Reset is synchronous; matrix stores are not cleared and need no clearing pass.
// The input stalls for the whole run; a held result word does not block a new load.
module matrix_power_by_squaring_core #(
   parameter int DIM_MAX   = 8,
   parameter int FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [2:0]         req_row,
   input  logic [2:0]         req_col,
   input  logic signed [31:0] req_value,
   input  logic [31:0]        req_exponent,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_out_row,
   output logic [2:0]         rsp_out_col,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_last,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_data
);
   import mpsq_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   mpsq_ctrl #(.DIM_MAX(DIM_MAX)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_exponent (req_exponent),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .stat         (stat),
      .cmd          (cmd)
   );

   mpsq_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last),
      .rsp_saturated (rsp_saturated)
   );

   // The final word always sits on the diagonal.
   a_last_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_row == rsp_out_col)
      else $error("last word off the diagonal");

   // A run word holds the input until its results are issued.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd |=> req_stall)
      else $error("run word did not stall the input");

   // No word follows the last one of a run directly.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_stall |=> !rsp_valid)
      else $error("word right after the last word");

   // The MAC never shares a cycle with the result reader or a load.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.mac_valid |-> !cmd.emit_valid && !cmd.load_en)
      else $error("MAC issue overlaps another command");

endmodule

>>> bench/tb_matrix_power_by_squaring_core.sv
module tb_matrix_power_by_squaring_core;
   import mpsq_pkg::*;

   localparam int DIM       = 8;
   localparam int FRAC      = 24;
   localparam int CYC_LIMIT = 10000000;
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef struct {
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] value;
      logic               last;
      logic               sat;
   } elem_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_cmd;
   logic [2:0]         req_row;
   logic [2:0]         req_col;
   logic signed [31:0] req_value;
   logic [31:0]        req_exponent;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [2:0]         rsp_out_row;
   logic [2:0]         rsp_out_col;
   logic signed [31:0] rsp_out_value;
   logic               rsp_last;
   logic               rsp_saturated;
   logic               csr_valid;
   logic               csr_ready;
   logic [3:0]         csr_data;

   elem_type           pending_elems[$];
   logic signed [31:0] base_m[DIM][DIM];
   logic signed [31:0] power_m[DIM][DIM];
   logic signed [31:0] prod_m[DIM][DIM];
   logic               sat_seen;
   logic [3:0]         size_reg;
   int                 mismatches;
   int                 cycles;
   bit                 no_idle;
   int                 stall_left;

   matrix_power_by_squaring_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_row(req_row), .req_col(req_col), .req_value(req_value),
      .req_exponent(req_exponent),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col), .rsp_out_value(rsp_out_value),
      .rsp_last(rsp_last), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp_word(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         sat_seen = 1'b1;
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         sat_seen = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fixed_mul(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return clamp_word(p >>> FRAC);
   endfunction

   // Multiplies the running power by itself or by the base matrix.
   task automatic multiply_power(input bit by_base, input int n);
      logic signed [31:0] acc;
      logic signed [31:0] rhs;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++) begin
               rhs = by_base ? base_m[k][j] : power_m[k][j];
               acc = clamp_word(64'(acc) + 64'(fixed_mul(power_m[i][k], rhs)));
            end
            prod_m[i][j] = acc;
         end
      end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            power_m[i][j] = prod_m[i][j];
   endtask

   task automatic predict_power(input logic [31:0] e);
      int       n;
      int       top;
      elem_type el;
      n = (size_reg == 0) ? 1 : (size_reg > DIM) ? DIM : size_reg;
      sat_seen = 1'b0;
      if (e == 0) begin
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
               power_m[i][j] = (i == j) ? (32'sd1 <<< FRAC) : 32'sd0;
      end else begin
         top = 31;
         while (!e[top]) top--;
         power_m = base_m;
         for (int b = top - 1; b >= 0; b--) begin
            multiply_power(1'b0, n);
            if (e[b]) multiply_power(1'b1, n);
         end
      end
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            el.row = i[2:0];
            el.col = j[2:0];
            el.value = power_m[i][j];
            el.last = (i == n - 1) && (j == n - 1);
            el.sat = sat_seen;
            pending_elems.push_back(el);
         end
      end
   endtask

   // Leaves req_valid high on return so a following word can go out back to back.
   task automatic send_word(input logic cmd, input logic [2:0] r, input logic [2:0] c,
                            input logic [31:0] v, input logic [31:0] e);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_row <= r;
      req_col <= c;
      req_value <= v;
      req_exponent <= e;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_LOAD) base_m[r][c] = v;
      else predict_power(e);
   endtask

   task automatic load(input int r, input int c, input logic [31:0] v);
      send_word(CMD_LOAD, r[2:0], c[2:0], v, $urandom);
   endtask

   task automatic run(input logic [31:0] e);
      send_word(CMD_RUN, 3'($urandom), 3'($urandom), $urandom, e);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_size(input logic [3:0] s);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= s;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = s;
   endtask

   function automatic logic [31:0] rand_fixed();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 2 << FRAC) - (1 << FRAC);
         2: return $urandom_range(0, 1 << (FRAC - 2)) - (1 << (FRAC - 3));
         default: return 0;
      endcase
   endfunction

   task automatic test_load_all();
      for (int r = 0; r < DIM; r++)
         for (int c = 0; c < DIM; c++)
            load(r, c, rand_fixed());
   endtask

   task automatic test_directed();
      write_size(4'd1);
      load(0, 0, 32'h7fffffff);
      run(32'd0);
      run(32'd1);
      run(32'd2);
      load(0, 0, 32'h80000000);
      run(32'd3);
      load(0, 0, 32'h01000000);
      run(32'hffffffff);
      load(7, 7, 32'h12345678);
      write_size(4'd0);
      run(32'd5);
      write_size(4'd15);
      run(32'd0);
      run(32'd1);
      write_size(4'd2);
      load(0, 1, 32'h7fffffff);
      load(1, 0, 32'h7fffffff);
      run(32'd2);
   endtask

   task automatic test_random_phases();
      int          n;
      int          cnt;
      logic [31:0] e;
      for (int ph = 0; ph < 12; ph++) begin
         write_size(4'($urandom_range(0, 15)));
         n = (size_reg == 0) ? 1 : (size_reg > DIM) ? DIM : size_reg;
         no_idle = (ph % 4 == 3);
         cnt = 0;
         while (cnt < 32) begin
            if ($urandom_range(0, 9) < 8) begin
               load($urandom_range(0, 7), $urandom_range(0, 7), rand_fixed());
            end else begin
               if (n <= 2) e = $urandom >> $urandom_range(0, 31);
               else if (n <= 4) e = $urandom_range(0, 40);
               else e = $urandom_range(0, 6);
               run(e);
            end
            cnt++;
         end
         if (ph == 5) wait_drained();
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_elems.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result word at %0d,%0d",
                                              rsp_out_row, rsp_out_col);
            end else begin
               elem_type x;
               x = pending_elems.pop_front();
               if (x.row !== rsp_out_row || x.col !== rsp_out_col ||
                   x.value !== rsp_out_value || x.last !== rsp_last ||
                   x.sat !== rsp_saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Result mismatch: expected %0d,%0d %h last %b sat %b,",
                               " got %0d,%0d %h last %b sat %b"},
                              x.row, x.col, x.value, x.last, x.sat, rsp_out_row,
                              rsp_out_col, rsp_out_value, rsp_last, rsp_saturated);
               end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 3);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYC_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_LOAD;
      req_row = 0;
      req_col = 0;
      req_value = 0;
      req_exponent = 0;
      csr_valid = 1'b0;
      csr_data = 0;
      rsp_stall = 1'b0;
      mismatches = 0;
      cycles = 0;
      no_idle = 1'b0;
      size_reg = 4'd8;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_load_all();
      test_directed();
      test_random_phases();
      wait_drained();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/mpsq_pkg.sv
hw/rtl/mpsq_ctrl.sv
hw/rtl/mpsq_datapath.sv
hw/rtl/matrix_power_by_squaring_core.sv
bench/tb_matrix_power_by_squaring_core.sv
